### sv/btseq_pkg.sv
// ----------------------------------------------------------------------------
// btseq_pkg
// Shared types and constants of the Bluetooth link set-up sequencer.
// ----------------------------------------------------------------------------
package btseq_pkg;

    localparam int LINE_KEEP = 3;
    localparam int LEN_W     = $clog2(LINE_KEEP + 1);
    localparam int IDX_W     = (LINE_KEEP > 1) ? $clog2(LINE_KEEP) : 1;
    localparam int TIME_W    = 16;
    localparam int CFG_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0] STATUS_PERIOD_RESET = TIME_W'(100);
    localparam logic [TIME_W-1:0] PAIR_PERIOD_RESET   = TIME_W'(500);
    localparam logic [TIME_W-1:0] TIME_MAX            = '1;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_I   = 8'h49;
    localparam logic [7:0] CH_V   = 8'h56;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_TWO = 8'h32;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RX      = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_DISC   = 2'd2,
        CMD_PAIR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        LS_SEARCH     = 2'd0,
        LS_CONNECTING = 2'd1,
        LS_CONNECTED  = 2'd2,
        LS_ERROR      = 2'd3
    } t_link;

    typedef enum logic [0:0] {
        CFG_STATUS_PERIOD = 1'b0,
        CFG_PAIR_PERIOD   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        EV_TICK    = 4'b0001,
        EV_CHAR    = 4'b0010,
        EV_LF      = 4'b0100,
        EV_RESTART = 4'b1000
    } t_ev_kind;

    typedef enum logic [3:0] {
        PH_STATUS = 4'b0001,
        PH_DISC   = 4'b0010,
        PH_PAIR   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_ev_kind   kind;
        logic [7:0] data;
    } t_event;

endpackage

### sv/btseq_front.sv
// ----------------------------------------------------------------------------
// btseq_front
// Accepts input items, classifies them and queues the events; drops CR and NOP.
// ----------------------------------------------------------------------------
module btseq_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_operation,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_ev_valid,
    output btseq_pkg::t_event      o_ev,
    input  logic                   i_ev_pop
);

    btseq_pkg::t_event                    r_queue [btseq_pkg::QUEUE_DEPTH];
    logic [btseq_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [btseq_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [btseq_pkg::QCNT_W-1:0]         r_count;
    btseq_pkg::t_event                    w_ev;
    logic                                 w_keep;
    logic                                 w_push;

    always_comb begin
        w_ev.data = i_rx_byte;
        w_ev.kind = btseq_pkg::EV_TICK;
        w_keep    = 1'b0;
        unique case (btseq_pkg::t_op'(i_operation))
            btseq_pkg::OP_TICK: begin
                w_ev.kind = btseq_pkg::EV_TICK;
                w_keep    = 1'b1;
            end
            btseq_pkg::OP_RX: begin
                if (i_rx_byte == btseq_pkg::CH_LF) begin
                    w_ev.kind = btseq_pkg::EV_LF;
                    w_keep    = 1'b1;
                end else if (i_rx_byte != btseq_pkg::CH_CR) begin
                    w_ev.kind = btseq_pkg::EV_CHAR;
                    w_keep    = 1'b1;
                end
            end
            btseq_pkg::OP_RESTART: begin
                w_ev.kind = btseq_pkg::EV_RESTART;
                w_keep    = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready    = (r_count != btseq_pkg::QCNT_W'(btseq_pkg::QUEUE_DEPTH));
    assign w_push     = i_valid && o_ready && w_keep;
    assign o_ev_valid = (r_count != '0);
    assign o_ev       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_ev_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !i_ev_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_ev_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_ev;
        end
    end

endmodule

### sv/btseq_back.sv
// ----------------------------------------------------------------------------
// btseq_back
// Executes queued events against the link phase, timer and reply line.
// ----------------------------------------------------------------------------
module btseq_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [btseq_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_ev_valid,
    input  btseq_pkg::t_event               i_ev,
    output logic                            o_ev_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_send_command,
    output logic [1:0]                      o_link_status
);

    logic [btseq_pkg::TIME_W-1:0]  r_status_period;
    logic [btseq_pkg::TIME_W-1:0]  r_pair_period;
    btseq_pkg::t_phase             r_phase;
    btseq_pkg::t_phase             n_phase;
    logic [btseq_pkg::TIME_W-1:0]  r_elapsed;
    logic [btseq_pkg::TIME_W-1:0]  n_elapsed;
    logic [btseq_pkg::LEN_W-1:0]   r_len;
    logic [btseq_pkg::LEN_W-1:0]   n_len;
    logic                          r_discard;
    logic                          n_discard;
    logic [7:0]                    r_chars [btseq_pkg::LINE_KEEP];
    logic                          w_store;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [1:0]                    r_cmd;
    logic [1:0]                    n_cmd;
    logic [1:0]                    r_status;
    logic [1:0]                    n_status;
    logic                          w_emit;
    logic [btseq_pkg::TIME_W-1:0]  w_inc;
    logic [btseq_pkg::TIME_W-1:0]  w_period;
    btseq_pkg::t_cmd               w_tick_cmd;
    logic [7:0]                    w_c0;
    logic [7:0]                    w_c1;
    logic [7:0]                    w_c2;
    btseq_pkg::t_phase             w_j_phase;
    logic                          w_j_clear;
    btseq_pkg::t_link              w_j_status;
    logic                          w_live;

    assign o_ev_pop = i_ev_valid && (!r_out_valid || i_ready);

    assign w_c0 = (r_len > btseq_pkg::LEN_W'(0)) ? r_chars[0] : 8'h00;
    assign w_c1 = (r_len > btseq_pkg::LEN_W'(1)) ? r_chars[1] : 8'h00;
    assign w_c2 = (r_len > btseq_pkg::LEN_W'(2)) ? r_chars[2] : 8'h00;

    always_comb begin
        w_j_phase  = r_phase;
        w_j_clear  = 1'b0;
        w_j_status = btseq_pkg::LS_SEARCH;
        unique case (r_phase)
            btseq_pkg::PH_STATUS: begin
                if (w_c0 == btseq_pkg::CH_M && w_c1 == btseq_pkg::CH_G &&
                    (w_c2 == btseq_pkg::CH_ONE || w_c2 == btseq_pkg::CH_TWO)) begin
                    w_j_phase = btseq_pkg::PH_PAIR;
                    w_j_clear = 1'b1;
                end else if ((w_c0 == btseq_pkg::CH_M && w_c1 == btseq_pkg::CH_G &&
                              w_c2 > btseq_pkg::CH_TWO) ||
                             (w_c0 == btseq_pkg::CH_I && w_c1 == btseq_pkg::CH_V)) begin
                    w_j_phase = btseq_pkg::PH_DISC;
                    w_j_clear = 1'b1;
                end else begin
                    w_j_status = btseq_pkg::LS_ERROR;
                end
            end
            btseq_pkg::PH_DISC: begin
                if (w_c0 == btseq_pkg::CH_I && w_c1 == btseq_pkg::CH_A) begin
                    w_j_phase = btseq_pkg::PH_PAIR;
                    w_j_clear = 1'b1;
                end else begin
                    w_j_status = btseq_pkg::LS_ERROR;
                end
            end
            default: begin
                if (w_c0 == btseq_pkg::CH_I && w_c1 == btseq_pkg::CH_I) begin
                    w_j_status = btseq_pkg::LS_SEARCH;
                end else if (w_c0 == btseq_pkg::CH_I && w_c1 == btseq_pkg::CH_V) begin
                    w_j_phase  = btseq_pkg::PH_DONE;
                    w_j_clear  = 1'b1;
                    w_j_status = btseq_pkg::LS_CONNECTED;
                end else begin
                    w_j_status = btseq_pkg::LS_ERROR;
                end
            end
        endcase
    end

    assign w_inc = (r_elapsed == btseq_pkg::TIME_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        unique case (r_phase)
            btseq_pkg::PH_PAIR: begin
                w_period   = r_pair_period;
                w_tick_cmd = btseq_pkg::CMD_PAIR;
            end
            btseq_pkg::PH_DISC: begin
                w_period   = r_status_period;
                w_tick_cmd = btseq_pkg::CMD_DISC;
            end
            default: begin
                w_period   = r_status_period;
                w_tick_cmd = btseq_pkg::CMD_STATUS;
            end
        endcase
    end

    assign w_live = !r_discard && (r_phase != btseq_pkg::PH_DONE);

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_len     = r_len;
        n_discard = r_discard;
        w_store   = 1'b0;
        w_emit    = 1'b0;
        n_cmd     = r_cmd;
        n_status  = r_status;
        if (o_ev_pop) begin
            unique case (i_ev.kind)
                btseq_pkg::EV_TICK: begin
                    if (r_phase != btseq_pkg::PH_DONE) begin
                        if (w_inc >= w_period) begin
                            n_elapsed = '0;
                            n_discard = 1'b0;
                            w_emit    = 1'b1;
                            n_cmd     = w_tick_cmd;
                            n_status  = btseq_pkg::LS_SEARCH;
                        end else begin
                            n_elapsed = w_inc;
                        end
                    end
                end
                btseq_pkg::EV_CHAR: begin
                    if (w_live && r_len < btseq_pkg::LEN_W'(btseq_pkg::LINE_KEEP)) begin
                        w_store = 1'b1;
                        n_len   = r_len + 1'b1;
                    end
                end
                btseq_pkg::EV_LF: begin
                    if (w_live && r_len != '0) begin
                        n_phase   = w_j_phase;
                        if (w_j_clear) begin
                            n_elapsed = '0;
                        end
                        n_len     = '0;
                        n_discard = 1'b1;
                        w_emit    = 1'b1;
                        n_cmd     = btseq_pkg::CMD_NONE;
                        n_status  = w_j_status;
                    end
                end
                default: begin
                    n_phase   = btseq_pkg::PH_STATUS;
                    n_elapsed = '0;
                    n_len     = '0;
                    n_discard = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_period <= btseq_pkg::STATUS_PERIOD_RESET;
            r_pair_period   <= btseq_pkg::PAIR_PERIOD_RESET;
            r_phase         <= btseq_pkg::PH_STATUS;
            r_elapsed       <= '0;
            r_len           <= '0;
            r_discard       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (btseq_pkg::t_cfg_idx'(i_cfg_index))
                    btseq_pkg::CFG_STATUS_PERIOD: r_status_period <= i_cfg_data;
                    default:                      r_pair_period   <= i_cfg_data;
                endcase
            end
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_len       <= n_len;
            r_discard   <= n_discard;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        if (w_store) begin
            r_chars[r_len[btseq_pkg::IDX_W-1:0]] <= i_ev.data;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_send_command = r_cmd;
    assign o_link_status  = r_status;

endmodule

### sv/bt_module_connect_sequencer_top.sv
// ----------------------------------------------------------------------------
// bt_module_connect_sequencer_top
// Link set-up sequencer for a serial Bluetooth module.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while o_ready is high:
// millisecond ticks, received bytes and restart requests. An accepted
// request is written into the two-entry event queue; at its head the back
// end evaluates timer, line store and reply decode in a single step and
// registers any result, which sets the sustained rate of one request per
// cycle while results are taken. A stalled result holds the back end, and
// once the queue holds two requests the input stalls as well. The user must
// write period registers only while the block is idle, which is not enforced.
module bt_module_connect_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [btseq_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_send_command,
    output logic [1:0]                      o_link_status
);

    logic              w_ev_valid;
    btseq_pkg::t_event w_ev;
    logic              w_ev_pop;

    btseq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .o_ev_valid  (w_ev_valid),
        .o_ev        (w_ev),
        .i_ev_pop    (w_ev_pop)
    );

    btseq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ev_valid     (w_ev_valid),
        .i_ev           (w_ev),
        .o_ev_pop       (w_ev_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_send_command (o_send_command),
        .o_link_status  (o_link_status)
    );

endmodule

### sv/btseq_checker.sv
// ----------------------------------------------------------------------------
// btseq_checker
// Port-level checks of the link set-up sequencer.
// ----------------------------------------------------------------------------
module btseq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_send_command,
    input logic [1:0] o_link_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_no_connecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_link_status != btseq_pkg::LS_CONNECTING))
        else $error("Connecting status reported.");

    a_cmd_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_command != btseq_pkg::CMD_NONE)
            |-> (o_link_status == btseq_pkg::LS_SEARCH))
        else $error("Command result with a status other than searching.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_send_command) && $stable(o_link_status)))
        else $error("Stalled result changed.");

endmodule

bind bt_module_connect_sequencer_top btseq_checker u_btseq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_send_command (o_send_command),
    .o_link_status  (o_link_status)
);
